// ===== rtl/core/ssr_pkg.sv =====
`default_nettype none

package ssr_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 4096;
    localparam int LANES      = 8;
    localparam int OUT_DEPTH  = 2;

    localparam logic [2:0] CFG_CENTER_X      = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y      = 3'd1;
    localparam logic [2:0] CFG_RADIUS        = 3'd2;
    localparam logic [2:0] CFG_INV_RADIUS_SQ = 3'd3;
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd4;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd5;
    localparam logic [2:0] CFG_LINE_STRIDE   = 3'd6;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] radius;
        logic [47:0] inv_radius_sq;
        logic [9:0]  image_width;
        logic [12:0] image_height;
        logic [15:0] line_stride;
    } cfg_t;

    // One row's span as handed from the front part to the back part.
    typedef struct packed {
        logic [27:0] row_base;
        logic [15:0] lx2;
        logic [11:0] il;
        logic [8:0]  ir;
        logic [31:0] dy2;
    } span_t;

    typedef struct packed {
        logic [27:0] byte_address;
        logic [8:0]  column_start;
        logic [63:0] pixel_bytes;
        logic [7:0]  byte_enable;
        logic        last_group;
    } group_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  lane;
        logic [27:0] addr;
        logic [8:0]  col;
        logic        last;
    } pix_t;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_PREP = 5'b00100,
        F_SQRT = 5'b01000,
        F_SPAN = 5'b10000
    } front_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssr_fifo.sv =====
`default_nettype none

module ssr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, wp_next;
    logic             rp_reg, rp_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ssr_front.sv =====
`default_nettype none

module ssr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  ssr_pkg::cfg_t  cfg,
    input  logic           push,
    input  logic [11:0]    row_index,
    output logic           full,
    output ssr_pkg::span_t span,
    output logic           span_valid,
    input  logic           span_ready
);
    import ssr_pkg::*;

    front_state_t state_reg, state_next;
    logic [11:0]  row_reg, row_next;
    logic [31:0]  dy2_reg, dy2_next;
    logic [31:0]  r2_reg, r2_next;
    logic [27:0]  base_reg, base_next;
    logic [31:0]  sx_reg, sx_next;
    logic [19:0]  rem_reg, rem_next;
    logic [15:0]  root_reg, root_next;
    logic [3:0]   cnt_reg, cnt_next;

    logic [9:0]         w_cl;
    logic [8:0]         w_m1;
    logic [12:0]        h_cl;
    logic [11:0]        h_m1;
    logic signed [17:0] lo_x, lo_y;
    logic [17:0]        hi_x, hi_y;
    logic [11:0]        lx, ly, ry;
    logic [8:0]         rx;
    logic               in_box;
    logic signed [17:0] dy;
    logic [15:0]        ady;
    logic [19:0]        rem_sh, trial;
    logic signed [16:0] cxm;
    logic [16:0]        cxp, rx16;
    logic [15:0]        lx16, lx2;
    logic [12:0]        rx2;
    logic [11:0]        il;
    logic [8:0]         ir;
    logic               nonempty;

    // Bounding box of the circle, clipped to the image.
    always_comb
    begin
        w_cl = cfg.image_width;
        if (w_cl == 10'd0)
        begin
            w_cl = 10'd1;
        end
        else if (w_cl > 10'(MAX_WIDTH))
        begin
            w_cl = 10'(MAX_WIDTH);
        end
        w_m1 = 9'(w_cl - 10'd1);
        h_cl = cfg.image_height;
        if (h_cl == 13'd0)
        begin
            h_cl = 13'd1;
        end
        else if (h_cl > 13'(MAX_HEIGHT))
        begin
            h_cl = 13'(MAX_HEIGHT);
        end
        h_m1 = 12'(h_cl - 13'd1);

        lo_x = $signed({2'b00, cfg.center_x}) - $signed({2'b00, cfg.radius});
        lo_y = $signed({2'b00, cfg.center_y}) - $signed({2'b00, cfg.radius});
        lx   = lo_x[17] ? 12'd0 : lo_x[15:4];
        ly   = lo_y[17] ? 12'd0 : lo_y[15:4];
        hi_x = {2'b00, cfg.center_x} + {2'b00, cfg.radius} + 18'd15;
        hi_y = {2'b00, cfg.center_y} + {2'b00, cfg.radius} + 18'd15;
        rx   = (hi_x[17:4] > {5'b0, w_m1}) ? w_m1 : hi_x[12:4];
        ry   = (hi_y[17:4] > {2'b0, h_m1}) ? h_m1 : hi_y[15:4];
        in_box = (row_reg >= ly) && (row_reg < ry);
    end

    // Span ends from the root.
    always_comb
    begin
        cxm  = $signed({1'b0, cfg.center_x}) - $signed({1'b0, root_reg});
        lx16 = {lx, 4'b0000};
        lx2  = (cxm > $signed({1'b0, lx16})) ? cxm[15:0] : lx16;
        cxp  = {1'b0, cfg.center_x} + {1'b0, root_reg};
        rx16 = {4'b0000, rx, 4'b0000};
        rx2  = (cxp < rx16) ? cxp[12:0] : rx16[12:0];
        il   = lx2[15:4];
        ir   = rx2[12:4];
        nonempty = ({3'b000, ir} > il);
    end

    assign full          = (state_reg != F_IDLE);
    assign span_valid    = (state_reg == F_SPAN) && nonempty;
    assign span.row_base = base_reg;
    assign span.lx2      = lx2;
    assign span.il       = il;
    assign span.ir       = ir;
    assign span.dy2      = dy2_reg;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        dy2_next   = dy2_reg;
        r2_next    = r2_reg;
        base_next  = base_reg;
        sx_next    = sx_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        dy         = $signed({2'b00, row_reg, 4'b0000}) - $signed({2'b00, cfg.center_y});
        ady        = dy[17] ? 16'(-dy) : dy[15:0];
        rem_sh     = {rem_reg[17:0], sx_reg[31:30]};
        trial      = {2'b00, root_reg, 2'b01};
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    row_next   = row_index;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                dy2_next   = 32'(ady) * 32'(ady);
                r2_next    = 32'(cfg.radius) * 32'(cfg.radius);
                base_next  = 28'(row_reg) * 28'(cfg.line_stride);
                state_next = in_box ? F_PREP : F_IDLE;
            end
            F_PREP:
            begin
                sx_next    = (r2_reg > dy2_reg) ? (r2_reg - dy2_reg) : 32'd0;
                rem_next   = 20'd0;
                root_next  = 16'd0;
                cnt_next   = 4'd15;
                state_next = F_SQRT;
            end
            F_SQRT:
            begin
                // One result bit per cycle, two radicand bits brought down each step.
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[14:0], 1'b0};
                end
                sx_next  = {sx_reg[29:0], 2'b00};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = F_SPAN;
                end
            end
            F_SPAN:
            begin
                if (!nonempty || span_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        dy2_reg  <= dy2_next;
        r2_reg   <= r2_next;
        base_reg <= base_next;
        sx_reg   <= sx_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_SQRT && cnt_reg == 4'd0) |=> (state_reg == F_SPAN))
        else $error("root iteration did not end in span state");

endmodule

`default_nettype wire

// ===== rtl/core/ssr_back.sv =====
`default_nettype none

module ssr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ssr_pkg::cfg_t   cfg,
    input  ssr_pkg::span_t  span,
    input  logic            span_valid,
    output logic            span_pop,
    input  logic            pop,
    output logic            empty,
    output ssr_pkg::group_t grp
);
    import ssr_pkg::*;

    logic        active_reg, active_next;
    span_t       cur_reg, cur_next;
    logic [5:0]  g_reg, g_next;
    logic [2:0]  k_reg, k_next;
    logic [1:0]  resv_reg, resv_next;

    logic [12:0]        col;
    logic [13:0]        col_end, lane_c;
    logic               grp_last, lane_en, issue, start;
    logic [12:0]        off;
    logic signed [18:0] dx;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    pix_t        p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [16:0] adx1_reg;
    logic [31:0] dy2_1_reg;
    logic [34:0] d2_reg;
    logic [58:0] plo_reg, phi_reg;
    logic        ovf_reg;
    logic [54:0] frac_reg;
    logic [8:0]  q_reg;
    logic        up_reg, zero_reg;

    logic [82:0] prod;
    logic [55:0] x;
    logic [63:0] t;
    logic [54:0] rem;
    logic [9:0]  qr;
    logic [7:0]  shade;
    logic [63:0] acc_bytes_reg, bytes_new;
    logic [7:0]  acc_en_reg, en_new;
    logic        grp_push, ofull;
    group_t      wgrp;
    logic [$bits(group_t)-1:0] rd_bits;

    assign col      = {1'b0, cur_reg.il} + {4'b0000, g_reg, 3'b000};
    assign col_end  = {1'b0, col} + 14'd8;
    assign grp_last = (col_end >= {5'b00000, cur_reg.ir}) || (g_reg == 6'd63);
    assign lane_c   = {1'b0, col} + {11'd0, k_reg};
    assign lane_en  = lane_c < {5'b00000, cur_reg.ir};
    assign off      = {g_reg, k_reg, 4'b0000};
    assign dx       = $signed({3'b000, cur_reg.lx2}) + $signed({6'd0, off})
                    - $signed({3'b000, cfg.center_x});

    // A group is started only when the output queue has a slot reserved for it.
    assign issue    = active_reg && ((k_reg != 3'd0) || (resv_reg < 2'(OUT_DEPTH)));
    assign start    = !active_reg && span_valid;
    assign span_pop = start;

    always_comb
    begin
        active_next = active_reg;
        cur_next    = cur_reg;
        g_next      = g_reg;
        k_next      = k_reg;
        if (start)
        begin
            active_next = 1'b1;
            cur_next    = span;
            g_next      = 6'd0;
            k_next      = 3'd0;
        end
        else if (issue)
        begin
            k_next = k_reg + 3'd1;
            if (k_reg == 3'd7)
            begin
                if (grp_last)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    g_next = g_reg + 6'd1;
                end
            end
        end
        resv_next = resv_reg;
        if ((issue && k_reg == 3'd0) && !(pop && !empty))
        begin
            resv_next = resv_reg + 2'd1;
        end
        else if (!(issue && k_reg == 3'd0) && (pop && !empty))
        begin
            resv_next = resv_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            resv_reg   <= 2'd0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            resv_reg   <= resv_next;
            v1_reg     <= issue;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            v5_reg     <= v4_reg;
        end
    end

    // Shade arithmetic: distance, scaled product, then rounding of 255*(1-P).
    always_comb
    begin
        prod = {24'd0, plo_reg} + {phi_reg, 24'd0};
        x    = {1'b1, 55'd0} - {1'b0, frac_reg};
        t    = {x, 8'd0} - {8'd0, x};
        rem  = t[54:0];
        qr   = {1'b0, q_reg} + {9'd0, up_reg};
        if (zero_reg)
        begin
            shade = 8'd0;
        end
        else if (qr > 10'd255)
        begin
            shade = 8'hff;
        end
        else
        begin
            shade = qr[7:0];
        end
        bytes_new = acc_bytes_reg;
        en_new    = acc_en_reg;
        for (int i = 0; i < LANES; i++)
        begin
            if (3'(i) == p5_reg.lane)
            begin
                bytes_new[8*i +: 8] = shade;
                en_new[i]           = p5_reg.en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        g_reg   <= g_next;
        k_reg   <= k_next;

        p1_reg.en   <= lane_en;
        p1_reg.lane <= k_reg;
        p1_reg.addr <= cur_reg.row_base + 28'(col);
        p1_reg.col  <= col[8:0];
        p1_reg.last <= grp_last;
        adx1_reg    <= dx[18] ? 17'(-dx) : dx[16:0];
        dy2_1_reg   <= cur_reg.dy2;

        p2_reg <= p1_reg;
        d2_reg <= 35'(adx1_reg) * 35'(adx1_reg) + 35'(dy2_1_reg);

        p3_reg  <= p2_reg;
        plo_reg <= 59'(d2_reg) * 59'(cfg.inv_radius_sq[23:0]);
        phi_reg <= 59'(d2_reg) * 59'(cfg.inv_radius_sq[47:24]);

        p4_reg   <= p3_reg;
        ovf_reg  <= |prod[82:55];
        frac_reg <= prod[54:0];

        p5_reg   <= p4_reg;
        q_reg    <= t[63:55];
        up_reg   <= (rem > {1'b1, 54'd0}) || ((rem == {1'b1, 54'd0}) && t[55]);
        zero_reg <= ovf_reg || !p4_reg.en;

        if (v5_reg)
        begin
            acc_bytes_reg <= bytes_new;
            acc_en_reg    <= en_new;
        end
    end

    assign grp_push          = v5_reg && (p5_reg.lane == 3'd7);
    assign wgrp.byte_address = p5_reg.addr;
    assign wgrp.column_start = p5_reg.col;
    assign wgrp.pixel_bytes  = bytes_new;
    assign wgrp.byte_enable  = en_new;
    assign wgrp.last_group   = p5_reg.last;

    ssr_fifo #(
        .WIDTH($bits(group_t))
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (grp_push),
        .wdata (wgrp),
        .pop   (pop),
        .rdata (rd_bits),
        .full  (ofull),
        .empty (empty)
    );

    assign grp = group_t'(rd_bits);

    a_resv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        resv_reg <= 2'(OUT_DEPTH))
        else $error("output reservations exceed queue depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        grp_push |-> !ofull)
        else $error("group completed with output queue full");

endmodule

`default_nettype wire

// ===== rtl/core/sphere_shade_span_rasterizer_top.sv =====
// Radial-falloff circle fill, one image row per input beat.
// Input channel: row_index is taken when push is high and full is low.
// Result channel: while empty is low the oldest 8-pixel group is on the
// result ports; it is taken when pop is high. A row gives 0 to 64 groups.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at once; write only while the block is idle.
// Per row the front part runs a clip and multiply step, a preparation step,
// a bit-serial square root, and a span step. The back part shades one pixel
// per cycle through a pipeline while an output queue slot can be reserved.
// A two-entry span queue lets the front work on the next row while the back
// part is still busy; full stays high while the front is busy.
// When the receiver stalls, at most two finished groups wait and the back
// part then holds its next group until a slot frees up.
// Reset clears all queues and control state and loads the register defaults.
`default_nettype none

module sphere_shade_span_rasterizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [11:0] row_index,
    output logic        empty,
    input  logic        pop,
    output logic [27:0] byte_address,
    output logic [8:0]  column_start,
    output logic [63:0] pixel_bytes,
    output logic [7:0]  byte_enable,
    output logic        last_group
);
    import ssr_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    span_t  span_w, span_q;
    logic   span_valid, span_full, span_empty, span_pop;
    logic [$bits(span_t)-1:0] span_bits;
    group_t grp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CENTER_X:      cfg_next.center_x      = cfg_data[15:0];
                CFG_CENTER_Y:      cfg_next.center_y      = cfg_data[15:0];
                CFG_RADIUS:        cfg_next.radius        = cfg_data[15:0];
                CFG_INV_RADIUS_SQ: cfg_next.inv_radius_sq = cfg_data;
                CFG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[9:0];
                CFG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[12:0];
                CFG_LINE_STRIDE:   cfg_next.line_stride   = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x      <= 16'd0;
            cfg_reg.center_y      <= 16'd0;
            cfg_reg.radius        <= 16'd16;
            cfg_reg.inv_radius_sq <= {1'b1, 47'd0};
            cfg_reg.image_width   <= 10'd512;
            cfg_reg.image_height  <= 13'd4096;
            cfg_reg.line_stride   <= 16'd512;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ssr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .row_index  (row_index),
        .full       (full),
        .span       (span_w),
        .span_valid (span_valid),
        .span_ready (!span_full)
    );

    ssr_fifo #(
        .WIDTH($bits(span_t))
    ) u_span_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (span_valid),
        .wdata (span_w),
        .pop   (span_pop),
        .rdata (span_bits),
        .full  (span_full),
        .empty (span_empty)
    );

    assign span_q = span_t'(span_bits);

    ssr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .span       (span_q),
        .span_valid (!span_empty),
        .span_pop   (span_pop),
        .pop        (pop),
        .empty      (empty),
        .grp        (grp)
    );

    assign byte_address = grp.byte_address;
    assign column_start = grp.column_start;
    assign pixel_bytes  = grp.pixel_bytes;
    assign byte_enable  = grp.byte_enable;
    assign last_group   = grp.last_group;

endmodule

`default_nettype wire

// ===== verif/ssr_checker.sv =====
`timescale 1ns / 1ps

module ssr_checker
    import ssr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [11:0] row_index,
    input  logic        empty,
    input  logic        pop,
    input  logic [27:0] byte_address,
    input  logic [8:0]  column_start,
    input  logic [63:0] pixel_bytes,
    input  logic [7:0]  byte_enable,
    input  logic        last_group,
    output int          errors,
    output int          outstanding
);

    localparam logic [127:0] SHADE_ONE = 128'h1 << 55;

    cfg_t     regs;
    group_t   expected_groups[$];

    assign outstanding = expected_groups.size();

    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] falloff_shade(input logic [63:0] d2);
        logic [127:0] prod;
        logic [127:0] scaled;
        logic [127:0] q;
        logic [127:0] rem;
        prod = {64'b0, d2} * {80'b0, regs.inv_radius_sq};
        if (prod >= SHADE_ONE) return 8'd0;
        scaled = (SHADE_ONE - prod) * 128'd255;
        q = scaled >> 55;
        rem = scaled & (SHADE_ONE - 1);
        // Round half to even.
        if (rem > (SHADE_ONE >> 1) || (rem == (SHADE_ONE >> 1) && q[0])) q = q + 1;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    task automatic shade_row(input logic [11:0] row_in);
        longint row, w, h, cx, cy, r, lx, rx, ly, ry, dy, dy2, r2, mx;
        longint lx2, rx2, il, ir, col, c, dx;
        int count;
        group_t g;
        row = row_in;
        w = regs.image_width;
        h = regs.image_height;
        cx = regs.center_x;
        cy = regs.center_y;
        r = regs.radius;
        count = 0;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        lx = (cx - r) >>> 4;
        if (lx < 0) lx = 0;
        rx = (cx + r + 15) >>> 4;
        if (rx > w - 1) rx = w - 1;
        ly = (cy - r) >>> 4;
        if (ly < 0) ly = 0;
        ry = (cy + r + 15) >>> 4;
        if (ry > h - 1) ry = h - 1;
        if (row < ly || row >= ry) return;
        dy = row * 16 - cy;
        dy2 = dy * dy;
        r2 = r * r;
        mx = root_of((r2 > dy2) ? r2 - dy2 : 0);
        lx2 = lx * 16;
        if (cx - mx > lx2) lx2 = cx - mx;
        rx2 = rx * 16;
        if (cx + mx < rx2) rx2 = cx + mx;
        il = lx2 / 16;
        ir = rx2 / 16;
        if (ir <= il) return;
        col = il;
        while (col < ir && count < 64)
        begin
            g = '0;
            for (int k = 0; k < LANES; k++)
            begin
                c = col + k;
                if (c < ir)
                begin
                    dx = lx2 + (c - il) * 16 - cx;
                    g.pixel_bytes[8*k +: 8] = falloff_shade(dx * dx + dy2);
                    g.byte_enable[k] = 1'b1;
                end
            end
            g.byte_address = row * regs.line_stride + col;
            g.column_start = col[8:0];
            g.last_group = (col + LANES >= ir || count + 1 == 64);
            expected_groups.push_back(g);
            count++;
            col += LANES;
        end
    endtask

    task automatic report(input string field, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.center_x <= 16'd0;
            regs.center_y <= 16'd0;
            regs.radius <= 16'd16;
            regs.inv_radius_sq <= 48'h1 << 47;
            regs.image_width <= 10'd512;
            regs.image_height <= 13'd4096;
            regs.line_stride <= 16'd512;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CENTER_X:      regs.center_x <= cfg_data[15:0];
                CFG_CENTER_Y:      regs.center_y <= cfg_data[15:0];
                CFG_RADIUS:        regs.radius <= cfg_data[15:0];
                CFG_INV_RADIUS_SQ: regs.inv_radius_sq <= cfg_data;
                CFG_IMAGE_WIDTH:   regs.image_width <= cfg_data[9:0];
                CFG_IMAGE_HEIGHT:  regs.image_height <= cfg_data[12:0];
                CFG_LINE_STRIDE:   regs.line_stride <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    initial errors = 0;

    always @(posedge clk)
    begin
        group_t want;
        if (rst_n && push && !full)
            shade_row(row_index);
        if (rst_n && pop && !empty)
        begin
            if (expected_groups.size() == 0)
            begin
                $display("unexpected group at %0t: address %h", $time, byte_address);
                errors++;
            end
            else
            begin
                want = expected_groups.pop_front();
                if (byte_address != want.byte_address)
                    report("byte_address", byte_address, want.byte_address);
                if (column_start != want.column_start)
                    report("column_start", column_start, want.column_start);
                if (pixel_bytes != want.pixel_bytes)
                    report("pixel_bytes", pixel_bytes, want.pixel_bytes);
                if (byte_enable != want.byte_enable)
                    report("byte_enable", byte_enable, want.byte_enable);
                if (last_group != want.last_group)
                    report("last_group", last_group, want.last_group);
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ssr_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = CFG_CENTER_X;
    logic [47:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [11:0] row_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [27:0] byte_address;
    logic [8:0]  column_start;
    logic [63:0] pixel_bytes;
    logic [7:0]  byte_enable;
    logic        last_group;
    int          errors;
    int          outstanding;
    int          cycles = 0;
    int          pop_hold = 0;

    always #5 clk = ~clk;

    sphere_shade_span_rasterizer_top DUT (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .push(push), .full(full), .row_index(row_index),
        .empty(empty), .pop(pop), .byte_address(byte_address),
        .column_start(column_start), .pixel_bytes(pixel_bytes),
        .byte_enable(byte_enable), .last_group(last_group)
    );

    ssr_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .push(push), .full(full), .row_index(row_index),
        .empty(empty), .pop(pop), .byte_address(byte_address),
        .column_start(column_start), .pixel_bytes(pixel_bytes),
        .byte_enable(byte_enable), .last_group(last_group),
        .errors(errors), .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // The receiver holds pop low for a random stretch after each decision.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            pop_hold <= pick_gap();
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic configure(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [15:0] r, input logic [47:0] inv,
                             input logic [9:0] w, input logic [12:0] h,
                             input logic [15:0] stride);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_INV_RADIUS_SQ, inv);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_LINE_STRIDE, stride);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Called at a falling edge; leaves push high for the accepted beat.
    task automatic send_row(input logic [11:0] row, input int gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        while (full)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        row_index <= row;
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [47:0] exact_inv(input logic [15:0] r);
        longint unsigned rr;
        rr = longint'(r) * longint'(r);
        return (64'h1 << 55) / rr;
    endfunction

    initial
    begin
        logic [15:0] cx, cy, r;
        logic [47:0] inv;
        longint base;
        int span;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: a one-pixel circle at the origin.
        send_row(12'd0, 0);
        send_row(12'd1, 0);
        send_row(12'd4095, 0);
        drain();

        // Circle wider than the image gives the maximum of 64 groups per row.
        configure(16'd4096, 16'd1600, 16'd4800, exact_inv(16'd4800), 10'd512,
                  13'd4096, 16'hFFFF);
        send_row(12'd100, 0);
        send_row(12'd0, 0);
        send_row(12'd399, 0);
        send_row(12'd4095, 1);
        drain();

        // Zero clip size and a zero reciprocal.
        configure(16'd40, 16'd40, 16'd64, 48'd0, 10'd0, 13'd0, 16'd0);
        send_row(12'd0, 0);
        send_row(12'd2, 0);
        drain();

        // Oversized clip size, the largest radius and a saturating reciprocal.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 10'h3FF,
                  13'h1FFF, 16'd777);
        send_row(12'd4094, 0);
        send_row(12'd2048, 0);
        send_row(12'd0, 0);
        drain();

        // Circle past the right edge of the image.
        configure(16'd60000, 16'd320, 16'd80, exact_inv(16'd80), 10'd512,
                  13'd100, 16'd512);
        send_row(12'd20, 0);
        send_row(12'd16, 0);
        drain();
        // Circle at a fractional position with a narrow image.
        configure(16'd37, 16'd53, 16'd29, exact_inv(16'd29), 10'd9, 13'd7, 16'd9);
        send_row(12'd0, 0);
        send_row(12'd1, 0);
        send_row(12'd3, 0);
        send_row(12'd5, 0);
        drain();

        for (int phase = 0; phase < 16; phase++)
        begin
            cx = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8400));
            cy = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60000));
            r = ($urandom_range(7) == 0) ? 16'($urandom_range(65535, 16))
                                         : 16'($urandom_range(1600, 16));
            inv = ($urandom_range(5) == 0) ? 48'({$urandom, $urandom}) : exact_inv(r);
            configure(cx, cy, r, inv,
                      ($urandom_range(5) == 0) ? 10'($urandom) : 10'($urandom_range(512, 8)),
                      ($urandom_range(5) == 0) ? 13'($urandom) : 13'd4096,
                      16'($urandom));
            span = r / 16 + 1;
            for (int n = 0; n < 22; n++)
            begin
                base = cy / 16 + $signed($urandom_range(2 * span)) - span;
                if ($urandom_range(4) == 0 || base < 0 || base > 4095)
                    send_row(12'($urandom), pick_gap());
                else
                    send_row(12'(base), pick_gap());
            end
            drain();
        end

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
